### design/imusd_pkg.sv
// Shared types and constants for the IMU stationary detector.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package imusd_pkg;

    localparam int unsigned THR_W     = 15;   // gravity and threshold registers
    localparam int unsigned CNT_W     = 9;    // window length and sample count
    localparam int unsigned SUM_W     = 40;   // running square sums
    localparam int unsigned CFG_W     = 15;   // config write data
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned LIM_W     = 2 * THR_W + CNT_W;
    localparam int unsigned QDEPTH    = 2;    // front-to-back queue entries

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    localparam logic [THR_W-1:0] GRAVITY_RST   = 15'd10040;
    localparam logic [THR_W-1:0] ACCEL_THR_RST = 15'd51;
    localparam logic [THR_W-1:0] RATE_THR_RST  = 15'd20;
    localparam logic [CNT_W-1:0] WIN_LEN_RST   = 9'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAVITY    = 2'd0,
        CFG_ACCEL_THR  = 2'd1,
        CFG_RATE_THR   = 2'd2,
        CFG_WINDOW_LEN = 2'd3
    } t_cfg_idx;

    // Settings the back end needs; len is already clamped to the window depth.
    typedef struct packed {
        logic [CNT_W-1:0] len;
        logic             clear;
        logic [THR_W-1:0] accel_thr;
        logic [THR_W-1:0] rate_thr;
    } t_back_cfg;

endpackage

### design/imusd_if.sv
// Channel interfaces: raw six-axis sample in, window statistics out.
// Depends on imusd_pkg for the result field widths.
`timescale 1ns / 1ps

interface imusd_sample_if #(parameter int SAMPLE_BITS = 16) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
    logic signed [SAMPLE_BITS-1:0] rate_x;
    logic signed [SAMPLE_BITS-1:0] rate_y;
    logic signed [SAMPLE_BITS-1:0] rate_z;

    modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                    input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                    output ready);
endinterface

interface imusd_result_if import imusd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] samples_held;
    logic [SUM_W-1:0] accel_square_sum;
    logic [SUM_W-1:0] rate_square_sum;
    logic             accel_quiet;
    logic             rate_quiet;
    logic             is_stationary;

    modport source (output valid, samples_held, accel_square_sum, rate_square_sum,
                    accel_quiet, rate_quiet, is_stationary, input ready);
    modport sink   (input valid, samples_held, accel_square_sum, rate_square_sum,
                    accel_quiet, rate_quiet, is_stationary, output ready);
endinterface

### design/imu_stationary_detector.sv
// IMU stationary detector, top level.
// A request passes F1, F2, the queue and the update and result registers.
// One request per cycle while no result is held; the window RAM does one read
// and one write per cycle, the oldest entry read one stage ahead of write-back.
// Reset: synchronous, active low; registers to defaults, window emptied. The
// window RAM is not swept: the fill count keeps unwritten entries from being used.
`timescale 1ns / 1ps

module imu_stationary_detector import imusd_pkg::*; #(
    parameter int WINDOW_DEPTH = 256,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    imusd_sample_if.sink         i_sample,
    imusd_result_if.source       o_result
);

    localparam int DW  = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1;
    localparam int AQW = 2 * DW - 1;
    localparam int RQW = 2 * SAMPLE_BITS;
    localparam int QW  = AQW + RQW;

    // config registers
    logic [THR_W-1:0] r_gravity;
    logic [THR_W-1:0] r_accel_thr;
    logic [THR_W-1:0] r_rate_thr;
    logic [CNT_W-1:0] r_win_len;
    logic [CNT_W-1:0] eff_len;
    logic             win_clear;
    t_back_cfg        back_cfg;

    // front-to-back queue
    logic          q_push, q_full, q_pop, q_empty;
    logic [QW-1:0] q_push_data, q_pop_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity   <= GRAVITY_RST;
            r_accel_thr <= ACCEL_THR_RST;
            r_rate_thr  <= RATE_THR_RST;
            r_win_len   <= WIN_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GRAVITY:    r_gravity   <= i_cfg_data[THR_W-1:0];
                CFG_ACCEL_THR:  r_accel_thr <= i_cfg_data[THR_W-1:0];
                CFG_RATE_THR:   r_rate_thr  <= i_cfg_data[THR_W-1:0];
                CFG_WINDOW_LEN: r_win_len   <= i_cfg_data[CNT_W-1:0];
            endcase
        end
    end

    // a length write also empties the window (same edge)
    assign win_clear = i_cfg_we && (t_cfg_idx'(i_cfg_index) == CFG_WINDOW_LEN);

    // zero acts as one; anything beyond the RAM depth is clamped to it
    always_comb begin
        if (r_win_len == '0) begin
            eff_len = CNT_W'(1);
        end else if (32'(r_win_len) > WINDOW_DEPTH) begin
            eff_len = CNT_W'(WINDOW_DEPTH);
        end else begin
            eff_len = r_win_len;
        end
    end

    always_comb begin
        back_cfg.len       = eff_len;
        back_cfg.clear     = win_clear;
        back_cfg.accel_thr = r_accel_thr;
        back_cfg.rate_thr  = r_rate_thr;
    end

    // front: register sample, square axes, add magnitudes (all-zero samples dropped)
    imusd_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gravity   (r_gravity),
        .i_sample    (i_sample),
        .o_push      (q_push),
        .o_push_data (q_push_data),
        .i_full      (q_full)
    );

    imusd_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (q_pop_data),
        .o_empty     (q_empty)
    );

    // back: slot pick + RAM read, sum update + write-back, result register
    imusd_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (back_cfg),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_q_data  (q_pop_data),
        .o_result  (o_result)
    );

`ifndef SYNTHESIS
    // the front must honor queue backpressure
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    // the back must not pop a missing entry
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    // stationary is only reported over a full window
    a_stat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.is_stationary) |-> (o_result.samples_held == eff_len))
        else $error("stationary flagged on a partial window");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result valid right after reset");
`endif

endmodule

### design/imusd_front.sv
// Front end: takes samples, drops all-zero ones, forms the two squared magnitudes.
// Depends on imusd_pkg and imusd_sample_if.
`timescale 1ns / 1ps

module imusd_front import imusd_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    localparam int DW  = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1,
    localparam int AQW = 2 * DW - 1,
    localparam int RQW = 2 * SAMPLE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [THR_W-1:0]     i_gravity,
    imusd_sample_if.sink         i_sample,
    output logic                 o_push,
    output logic [AQW+RQW-1:0]   o_push_data,
    input  logic                 i_full
);

    logic                          r_f1_valid;
    logic                          r_f2_valid;
    logic signed [SAMPLE_BITS-1:0] r_ax, r_ay, r_az, r_rx, r_ry, r_rz;
    logic [AQW-1:0]                r_sq_a [3];
    logic [RQW-1:0]                r_sq_r [3];

    logic                          accept, nonzero;
    logic                          f2_load_ok, f1_move, f1_load_ok;
    logic signed [DW-1:0]          ax_e, ay_e, grav_e, dz;
    logic signed [2*DW-1:0]        p_ax, p_ay, p_az;
    logic signed [RQW-1:0]         p_rx, p_ry, p_rz;
    logic [AQW-1:0]                sum_a;
    logic [RQW-1:0]                sum_r;

    // pipeline flow: F1 holds the raw sample, F2 the six squares
    assign o_push     = r_f2_valid && !i_full;
    assign f2_load_ok = !r_f2_valid || o_push;
    assign f1_move    = r_f1_valid && f2_load_ok;
    assign f1_load_ok = !r_f1_valid || f1_move;

    assign i_sample.ready = f1_load_ok;
    assign accept  = i_sample.valid && i_sample.ready;
    assign nonzero = |{i_sample.accel_x, i_sample.accel_y, i_sample.accel_z,
                       i_sample.rate_x, i_sample.rate_y, i_sample.rate_z};

    always_comb begin
        ax_e   = DW'(r_ax);
        ay_e   = DW'(r_ay);
        grav_e = DW'($signed({1'b0, i_gravity}));
        dz     = DW'(r_az) - grav_e;
        p_ax   = ax_e * ax_e;
        p_ay   = ay_e * ay_e;
        p_az   = dz * dz;
        p_rx   = r_rx * r_rx;
        p_ry   = r_ry * r_ry;
        p_rz   = r_rz * r_rz;
        sum_a  = r_sq_a[0] + r_sq_a[1] + r_sq_a[2];
        sum_r  = r_sq_r[0] + r_sq_r[1] + r_sq_r[2];
    end

    assign o_push_data = {sum_a, sum_r};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else begin
            if (accept && nonzero) begin
                r_f1_valid <= 1'b1;
            end else if (f1_move) begin
                r_f1_valid <= 1'b0;
            end
            if (f1_move) begin
                r_f2_valid <= 1'b1;
            end else if (o_push) begin
                r_f2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && nonzero) begin
            r_ax <= i_sample.accel_x;
            r_ay <= i_sample.accel_y;
            r_az <= i_sample.accel_z;
            r_rx <= i_sample.rate_x;
            r_ry <= i_sample.rate_y;
            r_rz <= i_sample.rate_z;
        end
        if (f1_move) begin
            r_sq_a[0] <= p_ax[AQW-1:0];
            r_sq_a[1] <= p_ay[AQW-1:0];
            r_sq_a[2] <= p_az[AQW-1:0];
            r_sq_r[0] <= p_rx[RQW-1:0];
            r_sq_r[1] <= p_ry[RQW-1:0];
            r_sq_r[2] <= p_rz[RQW-1:0];
        end
    end

endmodule

### design/imusd_queue.sv
// Short FIFO between the front and back ends.
// Depends on imusd_pkg for its depth.
`timescale 1ns / 1ps

module imusd_queue import imusd_pkg::*; #(
    parameter int WIDTH = 65
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data,
    output logic             o_empty
);

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    logic [WIDTH-1:0] r_mem [QDEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;

    assign o_full     = (r_count == CW'(QDEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

### design/imusd_back.sv
// Back end: sliding window store, saturating running sums and quiet tests.
// Depends on imusd_pkg and imusd_result_if.
`timescale 1ns / 1ps

module imusd_back import imusd_pkg::*; #(
    parameter int WINDOW_DEPTH = 256,
    parameter int SAMPLE_BITS  = 16,
    localparam int DW  = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1,
    localparam int AQW = 2 * DW - 1,
    localparam int RQW = 2 * SAMPLE_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_back_cfg          i_cfg,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    input  logic [AQW+RQW-1:0] i_q_data,
    imusd_result_if.source     o_result
);

    localparam int MAW  = $clog2(WINDOW_DEPTH);
    localparam int TA_W = ((AQW > SUM_W) ? AQW : SUM_W) + 1;
    localparam int TR_W = ((RQW > SUM_W) ? RQW : SUM_W) + 1;

    logic [AQW+RQW-1:0] r_mem [WINDOW_DEPTH];
    logic [AQW+RQW-1:0] r_rd_data, r_last, old_entry;

    logic [MAW-1:0]     r_slot, r_u_slot, slot_cur, slot_nxt;
    logic [CNT_W-1:0]   r_fill, n_fill, r_u_n, r_o_n;
    logic               full_now, full_after;
    logic               r_u_valid, r_u_full, r_u_stat, r_u_fwd;
    logic               r_o_valid, r_o_stat;
    logic [AQW-1:0]     r_u_a, old_a;
    logic [RQW-1:0]     r_u_r, old_r;
    logic [SUM_W-1:0]   r_sum_a, r_sum_r, n_sum_a, n_sum_r, r_o_sum_a, r_o_sum_r;
    logic [TA_W-1:0]    t_a, d_a;
    logic [TR_W-1:0]    t_r, d_r;
    logic [2*THR_W-1:0] r_accel_thr_sq, r_rate_thr_sq;
    logic [LIM_W-1:0]   r_o_lim_a, r_o_lim_r;
    logic               adv, pop, quiet_a, quiet_r;

    // whole back pipe moves together; it stalls only on a held result
    assign adv     = !r_o_valid || o_result.ready;
    assign pop     = adv && !i_q_empty;
    assign o_q_pop = pop;

    // issue stage: pick slot, update fill count
    always_comb begin
        slot_cur   = (32'(r_slot) >= 32'(i_cfg.len)) ? '0 : r_slot;
        slot_nxt   = (32'(slot_cur) + 32'd1 >= 32'(i_cfg.len)) ? '0
                   : MAW'(32'(slot_cur) + 32'd1);
        full_now   = (r_fill >= i_cfg.len);
        n_fill     = full_now ? i_cfg.len : r_fill + 1'b1;
        full_after = (n_fill >= i_cfg.len);
    end

    // update stage: oldest entry comes from the RAM or, for a one-slot window,
    // from the register holding the entry last written back
    always_comb begin
        old_entry = r_u_fwd ? r_last : r_rd_data;
        old_a     = r_u_full ? old_entry[AQW+RQW-1:RQW] : '0;
        old_r     = r_u_full ? old_entry[RQW-1:0] : '0;

        t_a     = TA_W'(r_sum_a) + TA_W'(r_u_a);
        d_a     = (t_a > TA_W'(old_a)) ? t_a - TA_W'(old_a) : '0;
        n_sum_a = (d_a > TA_W'(SUM_MAX)) ? SUM_MAX : d_a[SUM_W-1:0];

        t_r     = TR_W'(r_sum_r) + TR_W'(r_u_r);
        d_r     = (t_r > TR_W'(old_r)) ? t_r - TR_W'(old_r) : '0;
        n_sum_r = (d_r > TR_W'(SUM_MAX)) ? SUM_MAX : d_r[SUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_fill    <= '0;
            r_slot    <= '0;
            r_sum_a   <= '0;
            r_sum_r   <= '0;
        end else begin
            if (adv) begin
                r_u_valid <= pop;
                r_o_valid <= r_u_valid;
            end
            if (i_cfg.clear) begin
                r_fill  <= '0;
                r_slot  <= '0;
                r_sum_a <= '0;
                r_sum_r <= '0;
            end else begin
                if (pop) begin
                    r_fill <= n_fill;
                    r_slot <= slot_nxt;
                end
                if (adv && r_u_valid) begin
                    r_sum_a <= n_sum_a;
                    r_sum_r <= n_sum_r;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_accel_thr_sq <= i_cfg.accel_thr * i_cfg.accel_thr;
        r_rate_thr_sq  <= i_cfg.rate_thr * i_cfg.rate_thr;
        if (pop) begin
            r_u_slot <= slot_cur;
            r_u_full <= full_now;
            r_u_stat <= full_after;
            r_u_n    <= n_fill;
            r_u_a    <= i_q_data[AQW+RQW-1:RQW];
            r_u_r    <= i_q_data[RQW-1:0];
            r_u_fwd  <= r_u_valid && (r_u_slot == slot_cur);
        end
        if (adv && r_u_valid) begin
            r_last    <= {r_u_a, r_u_r};
            r_o_sum_a <= n_sum_a;
            r_o_sum_r <= n_sum_r;
            r_o_n     <= r_u_n;
            r_o_stat  <= r_u_stat;
            r_o_lim_a <= r_accel_thr_sq * r_u_n;
            r_o_lim_r <= r_rate_thr_sq * r_u_n;
        end
    end

    // window store: one read and one write port
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_rd_data <= r_mem[slot_cur];
        end
        if (adv && r_u_valid) begin
            r_mem[r_u_slot] <= {r_u_a, r_u_r};
        end
    end

    assign quiet_a = (r_o_sum_a < SUM_W'(r_o_lim_a));
    assign quiet_r = (r_o_sum_r < SUM_W'(r_o_lim_r));

    assign o_result.valid            = r_o_valid;
    assign o_result.samples_held     = r_o_n;
    assign o_result.accel_square_sum = r_o_sum_a;
    assign o_result.rate_square_sum  = r_o_sum_r;
    assign o_result.accel_quiet      = quiet_a;
    assign o_result.rate_quiet       = quiet_r;
    assign o_result.is_stationary    = r_o_stat && quiet_a && quiet_r;

endmodule
